[design/piu_pkg.sv]
// Shared types, constants and the field-count table of the packed index unpacker.
`default_nettype none
package piu_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WID_W   = 6;
	localparam int unsigned CNT_W   = 13;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned IDX_W   = 1;

	localparam logic [IDX_W-1:0] REG_BITS_PER_ENTRY = 1'd0;
	localparam logic [IDX_W-1:0] REG_ENTRY_COUNT    = 1'd1;

	localparam logic [WID_W-1:0] WID_RESET = 6'd4;
	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;
	localparam logic [WID_W-1:0] WID_MAX   = 6'd32;

	// One classified word waiting for the serializer.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] mask;
		logic [WID_W-1:0]  width;
		logic [WID_W-1:0]  per_word;
	} piu_entry_t;

	// Fields per 32-bit word for a field width of 1..32.
	function automatic logic [WID_W-1:0] fields_per_word(input logic [WID_W-1:0] w);
		logic [WID_W-1:0] n;
		unique case (w) inside
			6'd1:            n = 6'd32;
			6'd2:            n = 6'd16;
			6'd3:            n = 6'd10;
			6'd4:            n = 6'd8;
			6'd5:            n = 6'd6;
			6'd6:            n = 6'd5;
			6'd7, 6'd8:      n = 6'd4;
			[6'd9:6'd10]:    n = 6'd3;
			[6'd11:6'd16]:   n = 6'd2;
			default:         n = 6'd1;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

[design/piu_front.sv]
// Front end: accepts a packed word and classifies it by field width.
`default_nettype none
module piu_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte0,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte1,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte2,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte3,
	input  wire logic [piu_pkg::WID_W-1:0]   bits_per_entry,
	output logic                             ent_valid,
	input  wire logic                        ent_ready,
	output piu_pkg::piu_entry_t              ent
);
	import piu_pkg::*;

	logic             valid_s1;
	piu_entry_t       ent_s1;
	logic [WID_W-1:0] width;
	piu_entry_t       ent_d;

	// zero width reads as 1, anything above 32 as 32
	always_comb begin
		if (bits_per_entry == '0) begin
			width = 6'd1;
		end else if (bits_per_entry > WID_MAX) begin
			width = WID_MAX;
		end else begin
			width = bits_per_entry;
		end
		ent_d.word     = {byte3, byte2, byte1, byte0};
		ent_d.width    = width;
		ent_d.per_word = fields_per_word(width);
		ent_d.mask     = (width == WID_MAX) ? '1 : ((WORD_W'(1) << width) - WORD_W'(1));
	end

	assign in_ready  = !valid_s1 || ent_ready;
	assign ent_valid = valid_s1;
	assign ent       = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_s1 <= ent_d;
		end
	end

endmodule
`default_nettype wire

[design/piu_queue.sv]
// Two-entry queue between the front end and the serializer.
`default_nettype none
module piu_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire piu_pkg::piu_entry_t  push_ent,
	output logic                      pop_valid,
	input  wire logic                 pop,
	output piu_pkg::piu_entry_t       pop_ent
);
	import piu_pkg::*;

	piu_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_ent    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule
`default_nettype wire

[design/piu_back.sv]
// Serializer: emits one field per cycle while the output is not stalled and tracks the position in the array.
`default_nettype none
module piu_back #(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [piu_pkg::CNT_W-1:0]   entry_count,
	input  wire logic                        q_valid,
	output logic                             q_pop,
	input  wire piu_pkg::piu_entry_t         q_ent,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [piu_pkg::WORD_W-1:0]       entry_value,
	output logic [piu_pkg::POS_W-1:0]        entry_position,
	output logic                             word_done,
	output logic                             array_done
);
	import piu_pkg::*;

	localparam int unsigned CNT_CAP = (MAX_ENTRIES > 8191) ? 8191 : MAX_ENTRIES;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

	logic              busy_q;
	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] mask_q;
	logic [WID_W-1:0]  width_q;
	logic [WID_W-1:0]  left_q;
	logic [CNT_W-1:0]  done_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic [POS_W-1:0]  pos_q;
	logic              wdone_q;
	logic              adone_q;

	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  pos_nx;
	logic              last_arr;
	logic              last_word;
	logic              emit;

	always_comb begin
		if (entry_count == '0) begin
			count = CNT_W'(1);
		end else if (entry_count > CAP) begin
			count = CAP;
		end else begin
			count = entry_count;
		end
	end

	// a count lowered mid-array restarts the array
	assign pos       = (done_q >= count) ? '0 : done_q;
	assign pos_nx    = pos + CNT_W'(1);
	assign last_arr  = (pos_nx == count);
	assign last_word = (left_q == WID_W'(1)) || last_arr;
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign q_pop     = q_valid && (!busy_q || (emit && last_word));

	assign out_valid      = out_valid_q;
	assign entry_value    = value_q;
	assign entry_position = pos_q;
	assign word_done      = wdone_q;
	assign array_done     = adone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && last_word) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				done_q <= last_arr ? '0 : pos_nx;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q  <= q_ent.word;
			mask_q  <= q_ent.mask;
			width_q <= q_ent.width;
			left_q  <= q_ent.per_word;
		end else if (emit) begin
			data_q <= data_q >> width_q;
			left_q <= left_q - WID_W'(1);
		end
		if (emit) begin
			value_q <= data_q & mask_q;
			pos_q   <= pos[POS_W-1:0];
			wdone_q <= last_word;
			adone_q <= last_arr;
		end
	end

endmodule
`default_nettype wire

[design/packed_index_unpacker_core.sv]
// Top level of the packed index unpacker: config registers, front end, queue, serializer.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one 32-bit word as byte0..byte3,
//    byte0 least significant. Each word holds floor(32/bits_per_entry) fields.
//  - Output channel (out_valid/out_ready) gives one field per word transfer:
//    entry_value, entry_position, word_done on the last field of a word and
//    array_done on the last entry of an array (which also ends the word).
//  - Config port: cfg_we with cfg_idx 0 writes bits_per_entry, 1 writes
//    entry_count. Write only while the block is idle.
//  - Path: a word passes the front register, a queue slot and the serializer's
//    word register; its first field then shows from the output register.
//  - Throughput: one field per cycle while out_ready holds, set by the
//    serializer's output register. A word gives floor(32/width) fields (1 to 32),
//    fewer when an array ends inside it; the front end and two-entry queue keep
//    taking words meanwhile, so fields stream without gaps.
//  - Reset: bits_per_entry = 4, entry_count = 4096, array position 0, queue
//    and output empty.
//  - When the receiver stalls the output word holds, the serializer stops,
//    and in_ready drops once the queue and front register are full.
`default_nettype none
module packed_index_unpacker_core #(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [piu_pkg::IDX_W-1:0]   cfg_idx,
	input  wire logic [piu_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte0,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte1,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte2,
	input  wire logic [piu_pkg::BYTE_W-1:0]  byte3,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [piu_pkg::WORD_W-1:0]       entry_value,
	output logic [piu_pkg::POS_W-1:0]        entry_position,
	output logic                             word_done,
	output logic                             array_done
);
	import piu_pkg::*;

	logic [WID_W-1:0] bpe_q;
	logic [CNT_W-1:0] cnt_q;

	logic             fe_valid;
	logic             fe_ready;
	piu_entry_t       fe_ent;
	logic             q_valid;
	logic             q_pop;
	piu_entry_t       q_ent;

	// configuration registers, raw values; clamping happens where they are used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpe_q <= WID_RESET;
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BITS_PER_ENTRY: bpe_q <= cfg_wdata[WID_W-1:0];
				REG_ENTRY_COUNT:    cnt_q <= cfg_wdata[CNT_W-1:0];
				default:            ;
			endcase
		end
	end

	piu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte0          (byte0),
		.byte1          (byte1),
		.byte2          (byte2),
		.byte3          (byte3),
		.bits_per_entry (bpe_q),
		.ent_valid      (fe_valid),
		.ent_ready      (fe_ready),
		.ent            (fe_ent)
	);

	piu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_ent   (fe_ent),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_ent    (q_ent)
	);

	piu_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_count    (cnt_q),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_ent          (q_ent),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_value    (entry_value),
		.entry_position (entry_position),
		.word_done      (word_done),
		.array_done     (array_done)
	);

	// end of an array always closes the word
	a_array_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && array_done |-> word_done)
		else $error("array_done without word_done");

	// an accepted word is in the front register on the next cycle
	a_front_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> fe_valid)
		else $error("accepted word lost in front end");

	// the serializer only pulls from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// once a word is taken from the queue, a result follows unless the output stalls
	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && out_ready |=> ##1 out_valid)
		else $error("loaded word produced no result");

endmodule
`default_nettype wire

[verif/packed_index_unpacker_checker.sv]
// Checker for the packed index unpacker: tracks config, predicts unpacked entries, compares results.
`default_nettype none
module packed_index_unpacker_checker #(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [piu_pkg::IDX_W-1:0]    cfg_idx,
	input  wire logic [piu_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [piu_pkg::BYTE_W-1:0]   byte0,
	input  wire logic [piu_pkg::BYTE_W-1:0]   byte1,
	input  wire logic [piu_pkg::BYTE_W-1:0]   byte2,
	input  wire logic [piu_pkg::BYTE_W-1:0]   byte3,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [piu_pkg::WORD_W-1:0]   entry_value,
	input  wire logic [piu_pkg::POS_W-1:0]    entry_position,
	input  wire logic                         word_done,
	input  wire logic                         array_done,
	output int                                mismatches,
	output int                                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import piu_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic              word_last;
		logic              array_last;
	} unpacked_entry_t;

	logic [WID_W-1:0] width_reg;
	logic [CNT_W-1:0] count_reg;
	logic [CNT_W-1:0] array_pos;
	unpacked_entry_t  entries_due[$];
	unpacked_entry_t  want;
	int               fail_total = 0;
	int               due_count = 0;

	assign mismatches  = fail_total;
	assign outstanding = due_count;

	function automatic int unsigned field_width(input logic [WID_W-1:0] w);
		if (w == '0)
			return 1;
		if (w > WID_MAX)
			return 32'(WID_MAX);
		return 32'(w);
	endfunction

	function automatic int unsigned array_len(input logic [CNT_W-1:0] c);
		if (c == '0)
			return 1;
		if (c > MAX_ENTRIES)
			return MAX_ENTRIES;
		return 32'(c);
	endfunction

	// Splits one packed word into its fields, stopping early at the end of the array.
	task automatic unpack_word(input logic [WORD_W-1:0] word);
		int unsigned     w;
		int unsigned     n;
		int unsigned     per;
		logic [63:0]     mask;
		unpacked_entry_t e;
		w    = field_width(width_reg);
		n    = array_len(count_reg);
		per  = WORD_W / w;
		mask = (64'd1 << w) - 64'd1;
		// count lowered while mid-array: start a fresh array
		if (array_pos >= n)
			array_pos = '0;
		for (int unsigned k = 0; k < per; k++) begin
			e.value      = (word >> (k * w)) & mask[WORD_W-1:0];
			e.position   = array_pos[POS_W-1:0];
			e.array_last = (array_pos + 1 == n);
			e.word_last  = (k + 1 == per) || e.array_last;
			entries_due.push_back(e);
			if (e.array_last) begin
				array_pos = '0;
				break;
			end
			array_pos++;
		end
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_val,
			input logic [WORD_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WID_RESET;
			count_reg = CNT_RESET;
			array_pos = '0;
			entries_due.delete();
			due_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_BITS_PER_ENTRY)
					width_reg = cfg_wdata[WID_W-1:0];
				else if (cfg_idx == REG_ENTRY_COUNT)
					count_reg = cfg_wdata[CNT_W-1:0];
			end
			if (in_valid && in_ready)
				unpack_word({byte3, byte2, byte1, byte0});
			if (out_valid && out_ready) begin
				if (entries_due.size() == 0) begin
					$error("unexpected result: entry_value 0x%0h entry_position %0d",
						entry_value, entry_position);
					fail_total++;
				end else begin
					want = entries_due.pop_front();
					compare_field("entry_value", want.value, entry_value);
					compare_field("entry_position", WORD_W'(want.position),
						WORD_W'(entry_position));
					compare_field("word_done", WORD_W'(want.word_last), WORD_W'(word_done));
					compare_field("array_done", WORD_W'(want.array_last), WORD_W'(array_done));
				end
			end
			due_count <= entries_due.size();
		end
	end

endmodule
`default_nettype wire

[verif/packed_index_unpacker_core_test.sv]
// Testbench top for the packed index unpacker: clock, reset, word traffic, config phases, verdict.
`default_nettype none
module packed_index_unpacker_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import piu_pkg::*;

	localparam int unsigned MAX_ENTRIES = 4096;
	// cycles the receiver refuses output during the back-pressure test
	localparam int          LONG_HOLD   = 300;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_idx   = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  byte0     = '0;
	logic [BYTE_W-1:0]  byte1     = '0;
	logic [BYTE_W-1:0]  byte2     = '0;
	logic [BYTE_W-1:0]  byte3     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [WORD_W-1:0]  entry_value;
	logic [POS_W-1:0]   entry_position;
	logic               word_done;
	logic               array_done;

	int mismatches;
	int outstanding;

	// Traffic shaping knobs, flipped by the stimulus between phases.
	bit tx_gaps        = 1'b1;
	bit rx_gaps        = 1'b1;
	bit hold_requested = 1'b0;
	bit hold_taken     = 1'b0;

	packed_index_unpacker_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte0         (byte0),
		.byte1         (byte1),
		.byte2         (byte2),
		.byte3         (byte3),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_value   (entry_value),
		.entry_position(entry_position),
		.word_done     (word_done),
		.array_done    (array_done)
	);

	packed_index_unpacker_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte0         (byte0),
		.byte1         (byte1),
		.byte2         (byte2),
		.byte3         (byte3),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_value   (entry_value),
		.entry_position(entry_position),
		.word_done     (word_done),
		.array_done    (array_done),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop, sized for about 300 words of up to 32 entries each under random
	// receiver stalls.
	initial begin
		#15_000_000;
		$display("packed_index_unpacker_core_test NOT OK");
		$finish;
	end

	// Offer one packed word. Must be called right after a rising edge. Valid is
	// left high on return so a back-to-back word needs no low cycle in between.
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = tx_gaps ? $urandom_range(17, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{byte3, byte2, byte1, byte0} <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted entry has come out. The
	// checker registers its count, so it lags; hence the first edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Raw register values go straight to the port: zero, oversize and
	// upper-bit-polluted values exercise the block's own clamping.
	task automatic configure(input int unsigned width, input int unsigned count);
		wait_idle();
		write_reg(REG_BITS_PER_ENTRY, width);
		write_reg(REG_ENTRY_COUNT, count);
	endtask

	// Receiver: random stall before each field, plus one long hold on request
	// so the queue fills and in_ready drops while the sender keeps offering.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requested && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = rx_gaps ? $urandom_range(17, 0) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int unsigned width;
		int unsigned count;
		int          seg_words;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset settings: 4-bit fields, 4096-entry arrays
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8765_4321);

		// zero width acts as 1, zero count acts as 1: one entry per word,
		// array closes inside the word
		configure(0, 0);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);

		// upper config bits ignored (6-bit field -> 32), full-width fields
		configure(13'h1FE0, 3);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0001);
		send_word(32'hA5A5_A5A5);
		send_word(32'h5A5A_5A5A);

		// 5-bit fields with 2 pad bits, array of 7 ends in the first word (position carries over)
		configure(5, 7);
		send_word(32'h3FFF_FFFF);
		send_word(32'hC000_0000);
		send_word(32'h1234_5678);

		// counter past the count: 12 more entries into a 100-entry array, then
		// count lowered to 5 so the next word restarts at position 0
		configure(8, 100);
		send_word(32'h0403_0201);
		send_word(32'h0807_0605);
		send_word(32'h0C0B_0A09);
		configure(8, 5);
		send_word(32'hDDCC_BBAA);
		send_word(32'h4433_2211);

		// padding on top: 3-bit (2 pad bits), 17-bit (15), 31-bit (1)
		configure(3, 4096);
		send_word(32'hFFFF_FFFF);
		send_word(32'hC000_0000);
		configure(17, 2);
		send_word(32'hFFFF_FFFF);
		configure(31, 2);
		send_word(32'hFFFF_FFFF);
		// oversize width saturates to 32
		configure(33, 4095);
		send_word(32'hDEAD_BEEF);

		// --- random ---
		// 1-bit fields with oversize count (clamps to 4096): walks the
		// position all the way to 4095 and into the next array
		rx_gaps = 1'b0;
		configure(1, 8191);
		for (int i = 0; i < 130; i++)
			send_word($urandom);

		// back-pressure: receiver holds off while words keep coming
		rx_gaps = 1'b1;
		tx_gaps = 1'b0;
		configure(8, 50);
		hold_requested = 1'b1;
		for (int i = 0; i < 20; i++)
			send_word($urandom);

		// assorted settings; the array position carries over, so lowered
		// counts also land mid-array
		for (int seg = 0; seg < 6; seg++) begin
			if ($urandom_range(3, 0) == 0)
				width = $urandom_range(63, 0);
			else
				width = $urandom_range(32, 1);
			if ($urandom_range(3, 0) == 0)
				count = $urandom_range(8, 0);
			else
				count = $urandom_range(60, 1);
			configure(width, count);
			tx_gaps   = 1'($urandom_range(1, 0));
			rx_gaps   = 1'($urandom_range(1, 0));
			seg_words = 16;
			for (int i = 0; i < seg_words; i++)
				send_word($urandom);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("packed_index_unpacker_core_test OK");
		else
			$display("packed_index_unpacker_core_test NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
